// ===== sv/frie_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frie_pkg
// Shared opcodes, item classes and item / result types of the executor.
// ----------------------------------------------------------------------------
package frie_pkg;

  localparam int REG_COUNT_DEF  = 16;
  localparam int MEM_DEPTH_DEF  = 4096;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int WORD_STEP      = 4;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_SUB   = 5'd1;
  localparam logic [4:0] OP_MUL   = 5'd2;
  localparam logic [4:0] OP_DIV   = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_OR    = 5'd5;
  localparam logic [4:0] OP_XOR   = 5'd6;
  localparam logic [4:0] OP_MOVC  = 5'd7;
  localparam logic [4:0] OP_ADDL  = 5'd8;
  localparam logic [4:0] OP_SUBL  = 5'd9;
  localparam logic [4:0] OP_LOAD  = 5'd10;
  localparam logic [4:0] OP_LDI   = 5'd11;
  localparam logic [4:0] OP_STORE = 5'd12;
  localparam logic [4:0] OP_STI   = 5'd13;
  localparam logic [4:0] OP_CMP   = 5'd14;
  localparam logic [4:0] OP_BZ    = 5'd15;
  localparam logic [4:0] OP_BNZ   = 5'd16;
  localparam logic [4:0] OP_BP    = 5'd17;
  localparam logic [4:0] OP_BNP   = 5'd18;
  localparam logic [4:0] OP_JUMP  = 5'd19;
  localparam logic [4:0] OP_HALT  = 5'd20;
  localparam logic [4:0] OP_NOP   = 5'd21;

  localparam logic [3:0] KIND_NOP   = 4'd0;
  localparam logic [3:0] KIND_ALU   = 4'd1;
  localparam logic [3:0] KIND_MD    = 4'd2;
  localparam logic [3:0] KIND_LOAD  = 4'd3;
  localparam logic [3:0] KIND_STORE = 4'd4;
  localparam logic [3:0] KIND_CMP   = 4'd5;
  localparam logic [3:0] KIND_BR    = 4'd6;
  localparam logic [3:0] KIND_JUMP  = 4'd7;
  localparam logic [3:0] KIND_HALT  = 4'd8;

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  op;
    logic [3:0]  rd;
    logic [3:0]  r1;
    logic [3:0]  r2;
    logic [31:0] imm;
    logic [30:0] pc;
  } item_t;

  typedef struct packed {
    logic        we;
    logic [3:0]  wr;
    logic [31:0] wv;
    logic        we2;
    logic [3:0]  wr2;
    logic [31:0] wv2;
    logic        br;
    logic [30:0] tgt;
    logic        z;
    logic        p;
    logic        halted;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/frie_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/frie_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frie_front
// Classifies an incoming instruction and folds register indexes.
// ----------------------------------------------------------------------------
module frie_front import frie_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  wire logic [4:0]  action,
  input  wire logic [3:0]  dest_reg,
  input  wire logic [3:0]  src1_reg,
  input  wire logic [3:0]  src2_reg,
  input  wire logic [31:0] immediate,
  input  wire logic [30:0] instr_pc,
  output item_t            item
);

  localparam logic [6:0] RC = 7'(REG_COUNT);

  function automatic logic [3:0] fold(input logic [3:0] idx);
    logic [6:0] v;
    v = {3'b000, idx};
    for (int i = 0; i < 8; i++) begin
      if (v >= RC) v = v - RC;
    end
    return v[3:0];
  endfunction

  always_comb begin
    item.op  = action;
    item.rd  = fold(dest_reg);
    item.r1  = fold(src1_reg);
    item.r2  = fold(src2_reg);
    item.imm = immediate;
    item.pc  = instr_pc;
    unique case (action) inside
      OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_MOVC, OP_ADDL, OP_SUBL: item.kind = KIND_ALU;
      OP_MUL, OP_DIV:                item.kind = KIND_MD;
      OP_LOAD, OP_LDI:               item.kind = KIND_LOAD;
      OP_STORE, OP_STI:              item.kind = KIND_STORE;
      OP_CMP:                        item.kind = KIND_CMP;
      OP_BZ, OP_BNZ, OP_BP, OP_BNP:  item.kind = KIND_BR;
      OP_JUMP:                       item.kind = KIND_JUMP;
      OP_HALT:                       item.kind = KIND_HALT;
      default:                       item.kind = KIND_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/frie_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frie_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module frie_fifo import frie_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      din,
  output logic       full,
  input  wire logic  pop,
  output item_t      dout,
  output logic       empty
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  item_t          q [QUEUE_DEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        q[wptr] <= din;
        wptr    <= (wptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

// ===== sv/frie_mdu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frie_mdu
// Shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module frie_mdu #(
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          is_mul,
  input  wire logic [DW-1:0] a,
  input  wire logic [DW-1:0] b,
  output logic               done,
  output logic [DW-1:0]      res,
  output logic [DW-1:0]      rem
);

  localparam int CW = $clog2(DW + 1);

  logic          running;
  logic          mul;
  logic [CW-1:0] cnt;
  logic [DW-1:0] acc;
  logic [DW-1:0] x;
  logic [DW-1:0] y;
  logic [DW:0]   trial;

  assign trial = {rem, x[DW-1]} - {1'b0, y};
  assign res   = mul ? acc : x;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        mul     <= is_mul;
        cnt     <= '0;
        acc     <= '0;
        rem     <= '0;
        x       <= a;
        y       <= b;
      end else if (running) begin
        if (mul) begin
          if (y[0]) acc <= acc + x;
          x <= {x[DW-2:0], 1'b0};
          y <= {1'b0, y[DW-1:1]};
        end else if (!trial[DW]) begin
          rem <= trial[DW-1:0];
          x   <= {x[DW-2:0], 1'b1};
        end else begin
          rem <= {rem[DW-2:0], x[DW-1]};
          x   <= {x[DW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/frie_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frie_back
// Executes queued items against the register file, data store and flags.
// ----------------------------------------------------------------------------
module frie_back import frie_pkg::*; #(
  parameter int REG_COUNT  = REG_COUNT_DEF,
  parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  item_t      head,
  output logic       q_pop,
  output logic       clearing,
  output logic       out_valid,
  output result_t    out,
  input  wire logic  out_pop
);

  localparam int DW  = DATA_WIDTH;
  localparam int RIW = $clog2(REG_COUNT);
  localparam int AW  = $clog2(MEM_DEPTH);
  localparam bit POW2  = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;
  localparam bit IDENT = (DW < 17) && (MEM_DEPTH >= (1 << DW));
  localparam bit DIRECT = POW2 || IDENT;
  localparam logic [DW-1:0] DEPTH_W = DW'(MEM_DEPTH);
  localparam logic [DW-1:0] STEP    = DW'(WORD_STEP);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_READ = 4'd2;
  localparam logic [3:0] ST_EXEC = 4'd3;
  localparam logic [3:0] ST_MD   = 4'd4;
  localparam logic [3:0] ST_ADDR = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_MEM  = 4'd7;
  localparam logic [3:0] ST_WB2  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  function automatic logic [31:0] ext32(input logic [DW-1:0] v);
    return 32'({{32{v[DW-1]}}, v});
  endfunction

  logic [3:0]           state;
  item_t                cur;
  logic [DW-1:0]        a_q;
  logic [DW-1:0]        b_q;
  logic [AW-1:0]        addr_q;
  logic [AW-1:0]        clr_cnt;
  logic [REG_COUNT-1:0] vld;
  logic                 zf;
  logic                 pf;
  logic                 halt_seen;
  result_t              res_q;
  result_t              exec_res;
  result_t              res_d;
  logic                 deliver;

  logic [DW-1:0]  rf_rdata1;
  logic [DW-1:0]  rf_rdata2;
  logic [RIW-1:0] rf_raddr1;
  logic [RIW-1:0] rf_raddr2;
  logic           rf_we;
  logic [RIW-1:0] rf_waddr;
  logic [DW-1:0]  rf_wdata;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [DW-1:0]  mem_wdata;
  logic [DW-1:0]  mem_rdata;

  logic           md_start;
  logic           md_is_mul;
  logic [DW-1:0]  md_a;
  logic [DW-1:0]  md_b;
  logic           md_done;
  logic [DW-1:0]  md_res;
  logic [DW-1:0]  md_rem;

  logic [DW-1:0]  imm_dw;
  logic [DW-1:0]  alu_v;
  logic [DW-1:0]  md_v;
  logic [DW-1:0]  addr_base;
  logic [AW-1:0]  addr_direct;
  logic [DW-1:0]  ma;
  logic [DW-1:0]  mb;
  logic           na;
  logic           nb;
  logic           is_ldi;
  logic           is_sti;
  logic           br_cond;
  logic [63:0]    br_sum;
  logic [63:0]    jmp_sum;

  assign clearing  = (state == ST_CLR);
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign rf_raddr1 = (state == ST_IDLE) ? RIW'(head.r1) : RIW'(cur.r1);
  assign rf_raddr2 = (state == ST_IDLE) ? RIW'(head.r2) : RIW'(cur.r2);
  assign deliver   = (state == ST_DONE) && (!out_valid || out_pop);

  assign imm_dw    = DW'({{32{cur.imm[31]}}, cur.imm});
  assign na        = a_q[DW-1];
  assign nb        = b_q[DW-1];
  assign ma        = na ? DW'(0) - a_q : a_q;
  assign mb        = nb ? DW'(0) - b_q : b_q;
  assign is_ldi    = (cur.op == OP_LDI);
  assign is_sti    = (cur.op == OP_STI);
  assign addr_base = (cur.kind == KIND_LOAD) ? a_q + imm_dw : b_q + imm_dw;
  assign addr_direct = AW'({{AW{1'b0}}, addr_base});
  assign br_sum    = 64'(cur.pc) + 64'(imm_dw);
  assign jmp_sum   = 64'(a_q) + 64'(imm_dw);

  always_comb begin
    case (cur.op)
      OP_ADD:  alu_v = a_q + b_q;
      OP_SUB:  alu_v = a_q - b_q;
      OP_AND:  alu_v = a_q & b_q;
      OP_OR:   alu_v = a_q | b_q;
      OP_XOR:  alu_v = a_q ^ b_q;
      OP_MOVC: alu_v = imm_dw;
      OP_ADDL: alu_v = a_q + imm_dw;
      OP_SUBL: alu_v = a_q - imm_dw;
      default: alu_v = '0;
    endcase
    if (cur.op == OP_MUL) begin
      md_v = md_res;
    end else if (b_q == '0) begin
      md_v = '0;
    end else begin
      md_v = (na != nb) ? DW'(0) - md_res : md_res;
    end
    case (cur.op)
      OP_BZ:   br_cond = zf;
      OP_BNZ:  br_cond = !zf;
      OP_BP:   br_cond = pf;
      default: br_cond = !pf;
    endcase
  end

  always_comb begin
    exec_res = '0;
    if (!halt_seen) begin
      case (cur.kind)
        KIND_ALU: begin
          exec_res.we = 1'b1;
          exec_res.wr = cur.rd;
          exec_res.wv = ext32(alu_v);
        end
        KIND_BR: begin
          exec_res.br  = br_cond;
          exec_res.tgt = br_cond ? br_sum[30:0] : '0;
        end
        KIND_JUMP: begin
          exec_res.br  = 1'b1;
          exec_res.tgt = jmp_sum[30:0];
        end
        default: ;
      endcase
    end
    res_d        = res_q;
    res_d.z      = zf;
    res_d.p      = pf;
    res_d.halted = halt_seen;
  end

  always_comb begin
    md_start  = 1'b0;
    md_is_mul = (cur.op == OP_MUL);
    md_a      = addr_base;
    md_b      = DEPTH_W;
    if (cur.kind == KIND_MD) begin
      md_a = md_is_mul ? a_q : ma;
      md_b = md_is_mul ? b_q : mb;
    end
    if (state == ST_EXEC && !halt_seen) begin
      md_start = (cur.kind == KIND_MD) ||
                 (!DIRECT && (cur.kind == KIND_LOAD || cur.kind == KIND_STORE));
    end
    if (cur.kind != KIND_MD) md_is_mul = 1'b0;

    rf_we    = 1'b0;
    rf_waddr = RIW'(cur.rd);
    rf_wdata = alu_v;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = a_q;
    unique case (state)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_EXEC: rf_we = !halt_seen && (cur.kind == KIND_ALU);
      ST_MD: begin
        rf_we    = md_done;
        rf_wdata = md_v;
      end
      ST_ACC: begin
        if (cur.kind == KIND_STORE) begin
          mem_we   = 1'b1;
          rf_we    = is_sti;
          rf_waddr = RIW'(cur.r2);
          rf_wdata = b_q + STEP;
        end
      end
      ST_MEM: rf_wdata = mem_rdata;
      ST_WB2: begin
        rf_we    = 1'b1;
        rf_waddr = RIW'(cur.r1);
        rf_wdata = a_q + STEP;
      end
      default: ;
    endcase
    if (state == ST_MEM) rf_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      vld       <= '0;
      zf        <= 1'b0;
      pf        <= 1'b0;
      halt_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (deliver) out_valid <= 1'b1;
      else if (out_pop) out_valid <= 1'b0;
      if (rf_we) vld[rf_waddr] <= 1'b1;
      unique case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(MEM_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (!q_empty) begin
            cur   <= head;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          a_q   <= vld[RIW'(cur.r1)] ? rf_rdata1 : '0;
          b_q   <= vld[RIW'(cur.r2)] ? rf_rdata2 : '0;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          res_q <= exec_res;
          if (halt_seen) begin
            state <= ST_DONE;
          end else begin
            case (cur.kind)
              KIND_ALU: begin
                if (cur.op != OP_MOVC) begin
                  zf <= (alu_v == '0);
                  pf <= (alu_v != '0) && !alu_v[DW-1];
                end
                state <= ST_DONE;
              end
              KIND_MD: state <= ST_MD;
              KIND_LOAD, KIND_STORE: begin
                addr_q <= addr_direct;
                state  <= DIRECT ? ST_ACC : ST_ADDR;
              end
              KIND_CMP: begin
                zf    <= (a_q == b_q);
                pf    <= ($signed(a_q) > $signed(b_q));
                state <= ST_DONE;
              end
              KIND_HALT: begin
                halt_seen <= 1'b1;
                state     <= ST_DONE;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_MD: begin
          if (md_done) begin
            res_q.we <= 1'b1;
            res_q.wr <= cur.rd;
            res_q.wv <= ext32(md_v);
            zf       <= (md_v == '0);
            pf       <= (md_v != '0) && !md_v[DW-1];
            state    <= ST_DONE;
          end
        end
        ST_ADDR: begin
          if (md_done) begin
            addr_q <= AW'(md_rem);
            state  <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (cur.kind == KIND_STORE) begin
            res_q.we <= is_sti;
            res_q.wr <= is_sti ? cur.r2 : '0;
            res_q.wv <= is_sti ? ext32(b_q + STEP) : '0;
            state    <= ST_DONE;
          end else begin
            state <= ST_MEM;
          end
        end
        ST_MEM: begin
          res_q.we <= 1'b1;
          res_q.wr <= cur.rd;
          res_q.wv <= ext32(mem_rdata);
          if (is_ldi) begin
            res_q.we2 <= 1'b1;
            res_q.wr2 <= cur.r1;
            res_q.wv2 <= ext32(a_q + STEP);
            state     <= ST_WB2;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_WB2: state <= ST_DONE;
        ST_DONE: begin
          if (deliver) begin
            out   <= res_d;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  frie_ram #(.WIDTH(DW), .DEPTH(REG_COUNT)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr1), .rdata(rf_rdata1)
  );

  frie_ram #(.WIDTH(DW), .DEPTH(REG_COUNT)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr2), .rdata(rf_rdata2)
  );

  frie_ram #(.WIDTH(DW), .DEPTH(MEM_DEPTH)) u_dmem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(addr_q), .rdata(mem_rdata)
  );

  frie_mdu #(.DW(DW)) u_mdu (
    .clk(clk), .rst(rst), .start(md_start), .is_mul(md_is_mul),
    .a(md_a), .b(md_b), .done(md_done), .res(md_res), .rem(md_rem)
  );

endmodule
`default_nettype wire

// ===== sv/flagged_risc_instruction_executor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flagged_risc_instruction_executor
// Executes decoded instructions with a register file, data store and flags.
// ----------------------------------------------------------------------------
// Each item is one decoded instruction; each produces exactly one result item
// in order. A front stage classifies items into a two-entry queue, and a back
// sequencer executes them. Simple ops pass dequeue, register read, execute
// and deliver; stores add a data access, loads an access and a wait for the
// data RAM's registered read, and ldi a second register write; mul and div
// add a run of a bit-serial unit, as does address folding when MEM_DEPTH is
// not a power of two and below 2**DATA_WIDTH. After reset the data store is
// cleared one word per cycle, with full held high.
module flagged_risc_instruction_executor import frie_pkg::*; #(
  parameter int REG_COUNT  = REG_COUNT_DEF,
  parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [4:0]  action,
  input  wire logic [3:0]  dest_reg,
  input  wire logic [3:0]  src1_reg,
  input  wire logic [3:0]  src2_reg,
  input  wire logic [31:0] immediate,
  input  wire logic [30:0] instr_pc,
  output logic             empty,
  input  wire logic        pop,
  output logic             write_enable,
  output logic [3:0]       write_reg,
  output logic [31:0]      write_value,
  output logic             second_write_enable,
  output logic [3:0]       second_write_reg,
  output logic [31:0]      second_write_value,
  output logic             branch_taken,
  output logic [30:0]      branch_target,
  output logic             zero_out,
  output logic             positive_out,
  output logic             halted
);

  item_t   in_item;
  item_t   head;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  logic    clearing;
  logic    out_valid;
  result_t res;

  assign full  = q_full || clearing;
  assign empty = !out_valid;

  assign write_enable        = res.we;
  assign write_reg           = res.wr;
  assign write_value         = res.wv;
  assign second_write_enable = res.we2;
  assign second_write_reg    = res.wr2;
  assign second_write_value  = res.wv2;
  assign branch_taken        = res.br;
  assign branch_target       = res.tgt;
  assign zero_out            = res.z;
  assign positive_out        = res.p;
  assign halted              = res.halted;

  frie_front #(.REG_COUNT(REG_COUNT)) u_front (
    .action(action), .dest_reg(dest_reg), .src1_reg(src1_reg),
    .src2_reg(src2_reg), .immediate(immediate), .instr_pc(instr_pc),
    .item(in_item)
  );

  frie_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push && !full), .din(in_item), .full(q_full),
    .pop(q_pop), .dout(head), .empty(q_empty)
  );

  frie_back #(
    .REG_COUNT(REG_COUNT), .MEM_DEPTH(MEM_DEPTH), .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .head(head), .q_pop(q_pop),
    .clearing(clearing), .out_valid(out_valid), .out(res), .out_pop(pop)
  );

endmodule
`default_nettype wire

// ===== tb/flagged_risc_instruction_executor_checker.sv =====
// ----------------------------------------------------------------------------
// flagged_risc_instruction_executor_checker
// Watches the instruction and result queues, executes each accepted
// instruction against its own architectural state and compares every result.
// ----------------------------------------------------------------------------
module flagged_risc_instruction_executor_checker import frie_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [4:0]  action,
  input  wire logic [3:0]  dest_reg,
  input  wire logic [3:0]  src1_reg,
  input  wire logic [3:0]  src2_reg,
  input  wire logic [31:0] immediate,
  input  wire logic [30:0] instr_pc,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic        write_enable,
  input  wire logic [3:0]  write_reg,
  input  wire logic [31:0] write_value,
  input  wire logic        second_write_enable,
  input  wire logic [3:0]  second_write_reg,
  input  wire logic [31:0] second_write_value,
  input  wire logic        branch_taken,
  input  wire logic [30:0] branch_target,
  input  wire logic        zero_out,
  input  wire logic        positive_out,
  input  wire logic        halted,
  output int               errors,
  output int               pending
);

  logic [31:0] regs [16];
  logic [31:0] mem [4096];
  logic        zf, pf, hlt;
  result_t     expected_results[$];

  function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    if (mb == 0) return 32'd0;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  task automatic execute_instruction();
    result_t     r;
    logic [31:0] a, b, v;
    a = regs[src1_reg];
    b = regs[src2_reg];
    r = '0;
    if (!hlt) begin
      v = 0;
      case (action)
        OP_ADD:  v = a + b;
        OP_SUB:  v = a - b;
        OP_MUL:  v = a * b;
        OP_DIV:  v = quotient(a, b);
        OP_AND:  v = a & b;
        OP_OR:   v = a | b;
        OP_XOR:  v = a ^ b;
        OP_MOVC: v = immediate;
        OP_ADDL: v = a + immediate;
        OP_SUBL: v = a - immediate;
        default: ;
      endcase
      if (action <= OP_SUBL) begin
        r.we = 1; r.wr = dest_reg; r.wv = v;
        if (action != OP_MOVC) begin
          zf = (v == 0);
          pf = (v != 0) && !v[31];
        end
      end else if (action == OP_LOAD || action == OP_LDI) begin
        r.we = 1; r.wr = dest_reg; r.wv = mem[(a + immediate) % 4096];
        if (action == OP_LDI) begin
          r.we2 = 1; r.wr2 = src1_reg; r.wv2 = a + WORD_STEP;
        end
      end else if (action == OP_STORE || action == OP_STI) begin
        mem[(b + immediate) % 4096] = a;
        if (action == OP_STI) begin
          r.we = 1; r.wr = src2_reg; r.wv = b + WORD_STEP;
        end
      end else if (action == OP_CMP) begin
        zf = (a == b);
        pf = $signed(a) > $signed(b);
      end else if (action >= OP_BZ && action <= OP_BNP) begin
        case (action)
          OP_BZ:   r.br = zf;
          OP_BNZ:  r.br = !zf;
          OP_BP:   r.br = pf;
          default: r.br = !pf;
        endcase
        if (r.br) r.tgt = 31'({1'b0, instr_pc} + immediate);
      end else if (action == OP_JUMP) begin
        r.br = 1; r.tgt = 31'(a + immediate);
      end else if (action == OP_HALT) begin
        hlt = 1;
      end
      if (r.we) regs[r.wr] = r.wv;
      if (r.we2) regs[r.wr2] = r.wv2;
    end
    r.z = zf; r.p = pf; r.halted = hlt;
    expected_results.push_back(r);
  endtask

  task automatic compare_result();
    result_t e, g;
    g = '{write_enable, write_reg, write_value, second_write_enable, second_write_reg,
          second_write_value, branch_taken, branch_target, zero_out, positive_out, halted};
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, g);
      errors++;
      return;
    end
    e = expected_results.pop_front();
    if (g !== e) begin
      $display("%0t: result mismatch expected %h actual %h", $time, e, g);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (regs[i]) regs[i] = 0;
      foreach (mem[i]) mem[i] = 0;
      zf = 0; pf = 0; hlt = 0;
      errors = 0;
      expected_results.delete();
    end else begin
      if (pop && !empty) compare_result();
      if (push && !full) execute_instruction();
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/tb_flagged_risc_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// tb_flagged_risc_instruction_executor
// Drives directed and random instruction streams with varied push / pop
// pressure; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_flagged_risc_instruction_executor import frie_pkg::*;;

  localparam int WATCHDOG = 20000;

  logic        clk = 0, rst = 1, push = 0, pop = 0;
  logic [4:0]  action = 0;
  logic [3:0]  dest_reg = 0, src1_reg = 0, src2_reg = 0;
  logic [31:0] immediate = 0;
  logic [30:0] instr_pc = 0;
  logic        full, empty, write_enable, second_write_enable, branch_taken;
  logic        zero_out, positive_out, halted;
  logic [3:0]  write_reg, second_write_reg;
  logic [31:0] write_value, second_write_value;
  logic [30:0] branch_target;
  int          errors, pending, idle_cycles;
  int          push_idle_pct = 0, pop_stall_pct = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  flagged_risc_instruction_executor dut (.*);
  flagged_risc_instruction_executor_checker chk (.*);

  always @(negedge clk) pop <= ($urandom_range(99) >= pop_stall_pct);

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_instruction(logic [4:0] op, logic [3:0] rd, logic [3:0] r1,
                                  logic [3:0] r2, logic [31:0] imm);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1;
    action <= op; dest_reg <= rd; src1_reg <= r1; src2_reg <= r2;
    immediate <= imm; instr_pc <= 31'($urandom);
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [4:0]  op;
    logic [31:0] imm;
    op = ($urandom_range(49) == 0) ? 5'($urandom_range(31, 22)) : 5'($urandom_range(19));
    case ($urandom_range(3))
      0: imm = $urandom;
      1: imm = 32'($signed($urandom_range(64)) - 32);
      2: imm = {$urandom_range(1) ? 1'b1 : 1'b0, {31{$urandom_range(1) ? 1'b1 : 1'b0}}};
      default: imm = 32'($urandom_range(4095));
    endcase
    send_instruction(op, 4'($urandom), 4'($urandom), 4'($urandom), imm);
  endtask

  task automatic drain();
    push <= 0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_instruction(OP_MOVC, 1, 0, 0, 32'h8000_0000);
    send_instruction(OP_MOVC, 2, 0, 0, 32'hFFFF_FFFF);
    send_instruction(OP_MOVC, 3, 0, 0, 32'h7FFF_FFFF);
    send_instruction(OP_DIV, 4, 1, 2, 0);
    send_instruction(OP_DIV, 5, 3, 0, 0);
    send_instruction(OP_DIV, 6, 1, 3, 0);
    send_instruction(OP_MUL, 7, 3, 3, 0);
    send_instruction(OP_ADD, 8, 3, 2, 0);
    send_instruction(OP_SUB, 9, 3, 3, 0);
    send_instruction(OP_AND, 10, 1, 2, 0);
    send_instruction(OP_OR, 10, 1, 3, 0);
    send_instruction(OP_XOR, 10, 10, 10, 0);
    send_instruction(OP_ADDL, 11, 3, 0, 1);
    send_instruction(OP_SUBL, 12, 1, 0, 1);
    send_instruction(OP_STORE, 0, 3, 2, 32'h8000_0000);
    send_instruction(OP_LOAD, 13, 2, 0, 32'h8000_0000);
    send_instruction(OP_STI, 0, 3, 3, 5);
    send_instruction(OP_LDI, 14, 14, 0, 4095);
    send_instruction(OP_CMP, 0, 1, 3, 0);
    send_instruction(OP_BZ, 0, 0, 0, 32'hFFFF_FFFF);
    send_instruction(OP_BNZ, 0, 0, 0, 32'h7FFF_FFFF);
    send_instruction(OP_BP, 0, 0, 0, 8);
    send_instruction(OP_BNP, 0, 0, 0, 32'h8000_0000);
    send_instruction(OP_JUMP, 0, 2, 0, 32'hFFFF_FFFF);
    send_instruction(OP_NOP, 0, 0, 0, 0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      push_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 73 : 30) : 0;
      pop_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 73 : 30) : 0;
      for (int i = 0; i < 380; i++) send_random();
      drain();
    end
    push_idle_pct = 0; pop_stall_pct = 0;
    send_instruction(OP_HALT, 0, 0, 0, 0);
    for (int i = 0; i < 5; i++) send_random();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
